// ===== hw/rtl/pdlp_pkg.sv =====
`default_nettype none

package pdlp_pkg;

    localparam int SAMPLE_W = 8;
    localparam int LEVEL_W  = 8;
    localparam int COEFF_W  = 9;
    localparam int FILT_W   = 16;
    localparam int SUM_W    = 24;
    localparam int LEN_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;

    // Pulse must run longer than this before an end sample is honored
    localparam logic [LEN_W-1:0] MIN_LEN   = LEN_W'(40);
    localparam logic [LEN_W-1:0] LEN_MAX   = '1;
    localparam logic [LEN_W-1:0] LEN_ARMED = LEN_W'(2);
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;

    // Unity weight of the new sample in Q1.8
    localparam logic [COEFF_W-1:0] COEFF_ONE = COEFF_W'(256);

    localparam logic [LEVEL_W-1:0] START_LEVEL_RST = LEVEL_W'(5);
    localparam logic [LEVEL_W-1:0] END_LEVEL_RST   = LEVEL_W'(0);
    localparam logic [COEFF_W-1:0] COEFF_RST       = COEFF_ONE;

    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = CFG_IDX_W'(2);

    // First member lands in the highest bits
    typedef struct packed {
        logic [SUM_W-1:0]  gated_sum;
        logic [FILT_W-1:0] peak_value;
        logic [FILT_W-1:0] filtered;
        logic              pulse_valid;
        logic              ended;
        logic              started;
        logic              active;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== hw/rtl/pulse_detector_lowpass_peak.sv =====
// Threshold pulse detector with first-order low-pass and peak hold.
//
// Channels:
//   s_axis  - one 8-bit sample per request in tdata[7:0].
//   m_axis  - one result per sample; tdata packs active, started, ended,
//             pulse_valid, filtered (Q8.8), peak_value (Q8.8), gated_sum.
//   cfg     - register writes: index 0 start_level, 1 end_level,
//             2 filter_coeff (Q1.8, values above 256 act as 256). Always ready;
//             write only while no sample is in flight.
// Pipeline: input register, then result register. Throughput: one sample
//   per cycle while m_axis_tready holds high; the state update is a
//   single pass through two small multipliers, an adder and compares.
// Stall: when m_axis_tready is low the result register holds; the input
//   register still takes one more sample, then s_axis_tready drops.
// Reset: rst_n clears both pipeline stages, the pulse state (idle, filter,
//   peak, sum and length at zero) and loads the register reset values.
`default_nettype none

module pulse_detector_lowpass_peak (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [pdlp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [7:0] sample
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [0] active, [1] started, [2] ended, [3] pulse_valid, [19:4] filtered,
    // [35:20] peak_value, [59:36] gated_sum, [63:60] zero
    output logic [pdlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [pdlp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [pdlp_pkg::COEFF_W-1:0]         cfg_data
);
    import pdlp_pkg::*;

    // Configuration registers
    logic [LEVEL_W-1:0] start_level_reg;
    logic [LEVEL_W-1:0] end_level_reg;
    logic [COEFF_W-1:0] coeff_reg;

    // Input stage
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // Pulse state
    logic               capturing_reg;
    logic               capturing_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic [FILT_W-1:0]  filt_reg;
    logic [FILT_W-1:0]  filt_next;
    logic [FILT_W-1:0]  peak_reg;
    logic [FILT_W-1:0]  peak_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;

    // Result stage
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic advance;
    logic in_accept;
    logic update;
    logic trigger;
    logic end_hit;

    logic [COEFF_W-1:0]          coeff_sat;
    logic [COEFF_W-1:0]          coeff_rest;
    logic [FILT_W-1:0]           filt_in;
    logic [FILT_W-1:0]           peak_in;
    logic [SUM_W-1:0]            sum_in;
    logic [COEFF_W+SAMPLE_W-1:0] prod_new;
    logic [COEFF_W+FILT_W-1:0]   prod_old;
    logic [COEFF_W+FILT_W:0]     num;
    logic [SUM_W:0]              sum_wide;

    // Result register frees up when empty or when its request is taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, result_reg};

    // Single-pass update of the pulse state from the registered sample
    always_comb
    begin
        trigger    = !capturing_reg && (sample_reg > start_level_reg);
        update     = capturing_reg || trigger;

        coeff_sat  = (coeff_reg > COEFF_ONE) ? COEFF_ONE : coeff_reg;
        coeff_rest = COEFF_ONE - coeff_sat;

        // A trigger clears filter, peak and sum before the first update
        filt_in = capturing_reg ? filt_reg : '0;
        peak_in = capturing_reg ? peak_reg : '0;
        sum_in  = capturing_reg ? sum_reg  : '0;

        prod_new = coeff_sat * sample_reg;
        prod_old = coeff_rest * filt_in;
        num      = {1'b0, prod_new, 8'd0} + {1'b0, prod_old}
                   + (COEFF_W+FILT_W+1)'(128);

        if (update)
        begin
            filt_next = num[FILT_W+7:8];
        end
        else
        begin
            filt_next = filt_reg;
        end

        if (!update)
        begin
            peak_next = peak_reg;
        end
        else if (filt_next > peak_in)
        begin
            peak_next = filt_next;
        end
        else
        begin
            peak_next = peak_in;
        end

        // Gated sum saturates, and drops to zero on a quiet sample
        sum_wide = {1'b0, sum_in} + (SUM_W+1)'(sample_reg);
        if (!update)
        begin
            sum_next = sum_reg;
        end
        else if (sample_reg > start_level_reg)
        begin
            sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        end
        else
        begin
            sum_next = '0;
        end

        if (trigger)
        begin
            len_next = LEN_ARMED;
        end
        else if (capturing_reg && (len_reg != LEN_MAX))
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else
        begin
            len_next = len_reg;
        end

        end_hit        = capturing_reg && (len_next > MIN_LEN)
                         && (sample_reg <= end_level_reg);
        capturing_next = (capturing_reg || trigger) && !end_hit;

        result_next.active      = capturing_next;
        result_next.started     = trigger;
        result_next.ended       = end_hit;
        result_next.pulse_valid = end_hit && (peak_next > {end_level_reg, 8'd0});
        result_next.filtered    = filt_next;
        result_next.peak_value  = peak_next;
        result_next.gated_sum   = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_level_reg <= START_LEVEL_RST;
            end_level_reg   <= END_LEVEL_RST;
            coeff_reg       <= COEFF_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_LEVEL:  start_level_reg <= cfg_data[LEVEL_W-1:0];
                REG_END_LEVEL:    end_level_reg   <= cfg_data[LEVEL_W-1:0];
                REG_FILTER_COEFF: coeff_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input stage: hold while the result stage is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    // State and result advance together, once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            capturing_reg <= 1'b0;
            len_reg       <= '0;
            filt_reg      <= '0;
            peak_reg      <= '0;
            sum_reg       <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                capturing_reg <= capturing_next;
                len_reg       <= len_next;
                filt_reg      <= filt_next;
                peak_reg      <= peak_next;
                sum_reg       <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pdlp_checker.sv =====
`default_nettype none

module pdlp_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire [pdlp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [pdlp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire                              cfg_valid,
    input wire                              cfg_ready,
    input wire [pdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input wire [pdlp_pkg::COEFF_W-1:0]      cfg_data
);
    import pdlp_pkg::*;

    result_t res;
    assign res = m_axis_tdata[RESULT_W-1:0];

    // A stalled result request must hold
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pdlp: stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.started && res.ended))
        else $error("pdlp: pulse started and ended on one sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.pulse_valid |-> res.ended)
        else $error("pdlp: pulse_valid without end");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!res.started || res.active) && (!res.ended || !res.active))
        else $error("pdlp: active flag disagrees with start/end");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> res.peak_value >= res.filtered)
        else $error("pdlp: peak below filtered value");

endmodule

bind pulse_detector_lowpass_peak pdlp_checker u_pdlp_chk (.*);

`default_nettype wire

// ===== verif/pulse_detector_lowpass_peak_tb.sv =====
`default_nettype none

module pulse_detector_lowpass_peak_tb;
    import pdlp_pkg::*;

    // Two register stages between the sample request and its result.
    localparam int LATENCY     = 2;
    // Slowest legal run stays well under this, even when every sample waits
    // out both sides' longest gaps.
    localparam int CYCLE_LIMIT = 400_000;
    localparam int MAX_GAP     = 18;
    localparam int SOAK_LEN    = 300;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the detector state, predicts one result per
    // accepted sample and checks results in order.
    // ------------------------------------------------------------------
    class pulse_scoreboard;
        logic [LEVEL_W-1:0]  start_lvl;
        logic [LEVEL_W-1:0]  end_lvl;
        logic [COEFF_W-1:0]  coeff;
        bit                  capturing;
        logic [LEN_W-1:0]    run_len;
        logic [FILT_W-1:0]   lowpass;
        logic [FILT_W-1:0]   peak;
        logic [SUM_W-1:0]    gated;
        result_t             pending_q[$];
        int                  mismatches;
        int                  checked;
        int                  noted;
        int                  starts;
        int                  ends;
        int                  valid_ends;

        function new();
            start_lvl  = START_LEVEL_RST;
            end_lvl    = END_LEVEL_RST;
            coeff      = COEFF_RST;
            capturing  = 1'b0;
            run_len    = '0;
            lowpass    = '0;
            peak       = '0;
            gated      = '0;
            mismatches = 0;
            checked    = 0;
            noted      = 0;
            starts     = 0;
            ends       = 0;
            valid_ends = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] val);
            case (idx)
                REG_START_LEVEL:  start_lvl = val[LEVEL_W-1:0];
                REG_END_LEVEL:    end_lvl   = val[LEVEL_W-1:0];
                REG_FILTER_COEFF: coeff     = val;
                default: ;
            endcase
        endfunction

        // Advance the low-pass, the peak hold and the gated sum by one sample.
        function void absorb(logic [SAMPLE_W-1:0] x);
            int unsigned       weight;
            int unsigned       acc;
            logic [SUM_W:0]    wide_sum;
            weight  = (coeff > COEFF_ONE) ? 256 : coeff;
            acc     = weight * {x, 8'h00} + (256 - weight) * lowpass + 128;
            lowpass = acc[23:8];
            if (lowpass > peak)
                peak = lowpass;
            if (x > start_lvl) begin
                wide_sum = gated + x;
                gated    = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
            end else begin
                gated = '0;
            end
        endfunction

        // Note an accepted sample request and queue the result it causes.
        function void note_sample(logic [SAMPLE_W-1:0] x);
            result_t r;
            r = '0;
            if (!capturing) begin
                if (x > start_lvl) begin
                    capturing = 1'b1;
                    r.started = 1'b1;
                    run_len   = LEN_ARMED;
                    lowpass   = '0;
                    peak      = '0;
                    gated     = '0;
                    absorb(x);
                    starts++;
                end
            end else begin
                if (run_len != LEN_MAX)
                    run_len++;
                absorb(x);
                if (run_len > MIN_LEN && x <= end_lvl) begin
                    capturing     = 1'b0;
                    r.ended       = 1'b1;
                    r.pulse_valid = (peak > {end_lvl, 8'h00});
                    ends++;
                    if (r.pulse_valid)
                        valid_ends++;
                end
            end
            r.active     = capturing;
            r.filtered   = lowpass;
            r.peak_value = peak;
            r.gated_sum  = gated;
            pending_q.push_back(r);
            noted++;
        endfunction

        task report(string what, longint got, longint want);
            mismatches++;
            if (mismatches <= 25)
                $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                         $time, what, got, want, checked);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] word);
            result_t got;
            result_t want;
            checked++;
            got = word[RESULT_W-1:0];
            if (pending_q.size() == 0) begin
                report("result with no sample pending", word, 0);
                return;
            end
            want = pending_q.pop_front();
            if (got.active != want.active)
                report("active", got.active, want.active);
            if (got.started != want.started)
                report("started", got.started, want.started);
            if (got.ended != want.ended)
                report("ended", got.ended, want.ended);
            if (got.pulse_valid != want.pulse_valid)
                report("pulse_valid", got.pulse_valid, want.pulse_valid);
            if (got.filtered != want.filtered)
                report("filtered", got.filtered, want.filtered);
            if (got.peak_value != want.peak_value)
                report("peak_value", got.peak_value, want.peak_value);
            if (got.gated_sum != want.gated_sum)
                report("gated_sum", got.gated_sum, want.gated_sum);
            if (word[OUT_TDATA_W-1:RESULT_W] != '0)
                report("tdata pad bits", word[OUT_TDATA_W-1:RESULT_W], 0);
        endtask
    endclass

    // ------------------------------------------------------------------
    // Block under test and its stimulus signals. Every input starts known.
    // ------------------------------------------------------------------
    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    s_axis_tready;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [COEFF_W-1:0]      cfg_data      = '0;
    logic                    cfg_ready;

    pulse_scoreboard sb = new();

    bit no_idle        = 1'b0;  // drop all gaps on both sides while set
    int sent_count     = 0;
    int settings_count = 0;
    int cycle_count    = 0;

    pulse_detector_lowpass_peak dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] active, [1] started, [2] ended, [3] pulse_valid, [19:4] filtered,
        // [35:20] peak_value, [59:36] gated_sum, [63:60] zero
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: end the run as failed once the cycle limit is reached.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, sb.pending_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Idle cycles before the next request; at least a third of the draws are zero so
    // back-to-back traffic shows up even in busy phases.
    function automatic int draw_gap();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // ------------------------------------------------------------------
    // Sender side. tvalid stays high between back-to-back requests; it is
    // lowered only for gaps and drains, so each step sees one assignment.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        // Hold the request until the block takes it.
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        sb.note_sample(x);
        sent_count++;
    endtask

    // Hold off new requests until every result is back, then let the
    // pipeline settle before anything touches the registers.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Keep cfg_valid high across consecutive writes; program_regs lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEFF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(input logic [LEVEL_W-1:0] start_val,
                                input logic [LEVEL_W-1:0] end_val,
                                input logic [COEFF_W-1:0] coeff_val);
        write_reg(REG_START_LEVEL, {1'b0, start_val});
        write_reg(REG_END_LEVEL, {1'b0, end_val});
        write_reg(REG_FILTER_COEFF, coeff_val);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // Body samples stay above the end level so the pulse runs its full
    // length; now and then drop in an arbitrary sample that may end it early.
    function automatic logic [SAMPLE_W-1:0] body_sample();
        if (sb.end_lvl == '1 || $urandom_range(0, 24) == 0)
            return SAMPLE_W'($urandom_range(0, 255));
        return SAMPLE_W'($urandom_range(sb.end_lvl + 1, 255));
    endfunction

    // One well-formed pulse: quiet lead-in, trigger, body, ending sample.
    // Body lengths straddle the minimum-length boundary; a few run long
    // enough to saturate the length count.
    task automatic send_pulse();
        int lead;
        int body;
        lead = $urandom_range(0, 6);
        repeat (lead) send_sample(SAMPLE_W'($urandom_range(0, sb.start_lvl)));
        if (sb.start_lvl == '1)
            return;
        send_sample(SAMPLE_W'($urandom_range(sb.start_lvl + 1, 255)));
        body = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300)
                                           : $urandom_range(37, 70);
        repeat (body) send_sample(body_sample());
        send_sample(SAMPLE_W'($urandom_range(0, sb.end_lvl)));
    endtask

    // ------------------------------------------------------------------
    // Receiver side: draw a stall before every result, then accept it.
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        logic [SAMPLE_W-1:0] opener [20];
        logic [LEVEL_W-1:0]  start_val;
        logic [LEVEL_W-1:0]  end_val;
        logic [COEFF_W-1:0]  coeff_val;
        int                  target;

        // Idle samples at and below the start level, a trigger at exactly
        // one above it, full-scale and zero samples, walking bits.
        opener = '{8'd0, 8'd5, 8'd3, 8'd6, 8'd255, 8'd0, 8'd255, 8'd170, 8'd85, 8'd5,
                   8'd6, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128, 8'd255};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opener under the reset register values.
        foreach (opener[i])
            send_sample(opener[i]);
        wait_drained();

        // Random phases: fixed corner settings first, then random ones.
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: begin start_val = 8'd0;   end_val = 8'd255; coeff_val = 9'd0;   end
                1: begin start_val = 8'd255; end_val = 8'd0;   coeff_val = 9'd511; end
                2: begin start_val = 8'd10;  end_val = 8'd0;   coeff_val = 9'd128; end
                3: begin start_val = 8'd3;   end_val = 8'd200; coeff_val = 9'd257; end
                4: begin start_val = 8'd20;  end_val = 8'd8;   coeff_val = 9'd256; end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       start_val = 8'd0;
                        1:       start_val = 8'd255;
                        2:       start_val = LEVEL_W'($urandom_range(0, 255));
                        default: start_val = LEVEL_W'($urandom_range(0, 40));
                    endcase
                    case ($urandom_range(0, 5))
                        0:       end_val = 8'd0;
                        1:       end_val = 8'd255;
                        2:       end_val = LEVEL_W'($urandom_range(0, 255));
                        default: end_val = LEVEL_W'($urandom_range(0, 30));
                    endcase
                    case ($urandom_range(0, 5))
                        0:       coeff_val = 9'd0;
                        1:       coeff_val = COEFF_ONE;
                        2:       coeff_val = COEFF_W'($urandom_range(257, 511));
                        3:       coeff_val = 9'd1;
                        default: coeff_val = COEFF_W'($urandom_range(0, 256));
                    endcase
                end
            endcase
            program_regs(start_val, end_val, coeff_val);

            // Every fourth phase runs without gaps on either side.
            no_idle = (phase % 4 == 3);
            target  = sent_count + 40;
            while (sent_count < target) begin
                if ($urandom_range(0, 4) != 0)
                    send_pulse();
                else
                    repeat ($urandom_range(1, 15))
                        send_sample(SAMPLE_W'($urandom_range(0, 255)));
            end
            no_idle = 1'b0;
            wait_drained();
        end

        // Soak: one full-rate pulse of large samples, long enough to drive
        // the length count into saturation, then end it.
        program_regs(8'd0, 8'd0, COEFF_ONE);
        no_idle = 1'b1;
        send_sample(8'd0);
        repeat (SOAK_LEN) send_sample(SAMPLE_W'($urandom_range(240, 255)));
        send_sample(8'd0);
        no_idle = 1'b0;
        wait_drained();

        $display("Checked %0d results for %0d samples under %0d register settings.",
                 sb.checked, sb.noted, settings_count);
        $display("Pulses: %0d started, %0d ended (%0d valid); %0d mismatches.",
                 sb.starts, sb.ends, sb.valid_ends, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== pulse_detector_lowpass_peak.f =====
hw/rtl/pdlp_pkg.sv
hw/rtl/pulse_detector_lowpass_peak.sv
hw/rtl/pdlp_checker.sv
verif/pulse_detector_lowpass_peak_tb.sv
